// ===== design/dsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and fixed widths for the disjoint-set union block.
// No dependencies; imported by dsu_front, dsu_back and the top module.
package dsu_pkg;

   // Request codes on req_type
   typedef enum logic [0:0] {
      OP_MERGE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   localparam int IDX_IN_W    = 10;  // width of an index on the request ports
   localparam int SIZE_OUT_W  = 11;  // width of set_size on the result ports
   localparam int RECIP_SHIFT = 20;  // fixed-point shift of the modulo reciprocal

   // Back-end sequencer states
   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_ID      = 7'b0000100,
      ST_QSIZE   = 7'b0001000,
      ST_SIZE    = 7'b0010000,
      ST_WALK    = 7'b0100000,
      ST_SPLICE1 = 7'b1000000
   } state_type;

endpackage

// ===== design/dsu_fifo.sv =====
`timescale 1ns / 1ps
// Small register FIFO with push/full and pop/empty handshakes.
// Standalone; used for the command queue and the result queue.
module dsu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/dsu_front.sv =====
`timescale 1ns / 1ps
// Request front end: accepts requests, folds indices into range, queues commands.
// Depends on dsu_pkg.
module dsu_front #(
   parameter int MAX_PEOPLE = 1024,
   parameter int IDX_W      = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  dsu_pkg::op_type                req_type,
   input  logic [dsu_pkg::IDX_IN_W-1:0]   req_first_index,
   input  logic [dsu_pkg::IDX_IN_W-1:0]   req_second_index,
   input  logic                           hold,
   output logic                           cmd_push,
   output logic [2*IDX_W:0]               cmd_data,
   input  logic                           cmd_full
);
   import dsu_pkg::*;

   localparam int NW     = $clog2(MAX_PEOPLE + 1);
   localparam int RW     = IDX_IN_W + NW;
   localparam int PROD_W = IDX_IN_W + RECIP_SHIFT;
   localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((1 << RECIP_SHIFT) / MAX_PEOPLE);

   logic                s1_vld_ff, s1_vld_in;
   op_type              s1_op_ff;
   logic [IDX_IN_W-1:0] s1_a_ff, s1_b_ff;
   logic                s2_vld_ff, s2_vld_in;
   op_type              s2_op_ff;
   logic [IDX_IN_W-1:0] s2_a_ff, s2_b_ff;
   logic [IDX_IN_W-1:0] s2_qa_ff, s2_qb_ff;
   logic [PROD_W-1:0]   prod_a, prod_b;
   logic [IDX_W-1:0]    elem_a, elem_b;
   logic                advance, accept;

   // raw - q*N with one correction step; q is exact or one short
   function automatic logic [IDX_W-1:0] fold(input logic [IDX_IN_W-1:0] raw,
                                             input logic [IDX_IN_W-1:0] q);
      logic [RW-1:0] qn;
      logic [RW-1:0] rem;
      qn  = RW'(q) * RW'(MAX_PEOPLE);
      rem = RW'(raw) - qn;
      if (rem >= RW'(MAX_PEOPLE)) begin
         rem = rem - RW'(MAX_PEOPLE);
      end
      return rem[IDX_W-1:0];
   endfunction

   assign advance  = !s2_vld_ff || !cmd_full;
   assign full     = !advance || hold;
   assign accept   = push && !full;
   assign cmd_push = s2_vld_ff && !cmd_full;

   assign prod_a = PROD_W'(s1_a_ff) * PROD_W'(RECIP);
   assign prod_b = PROD_W'(s1_b_ff) * PROD_W'(RECIP);

   assign elem_a   = fold(s2_a_ff, s2_qa_ff);
   assign elem_b   = fold(s2_b_ff, s2_qb_ff);
   assign cmd_data = {s2_op_ff, elem_a, elem_b};

   always_comb begin
      s1_vld_in = s1_vld_ff;
      s2_vld_in = s2_vld_ff;
      if (advance) begin
         s1_vld_in = accept;
         s2_vld_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff <= req_type;
         s1_a_ff  <= req_first_index;
         s1_b_ff  <= req_second_index;
         s2_op_ff <= s1_op_ff;
         s2_a_ff  <= s1_a_ff;
         s2_b_ff  <= s1_b_ff;
         s2_qa_ff <= prod_a[PROD_W-1:RECIP_SHIFT];
         s2_qb_ff <= prod_b[PROD_W-1:RECIP_SHIFT];
      end
   end

endmodule

// ===== design/dsu_back.sv =====
`timescale 1ns / 1ps
// Command back end: set-id, size and member-list memories and the merge/query sequencer.
// Depends on dsu_pkg.
module dsu_back #(
   parameter int MAX_PEOPLE = 1024,
   parameter int IDX_W      = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_empty,
   input  logic [2*IDX_W:0]                 cmd_data,
   output logic                             cmd_pop,
   output logic                             rsp_push,
   output logic [dsu_pkg::SIZE_OUT_W-1:0]   rsp_data,
   input  logic                             rsp_full,
   output logic                             clearing
);
   import dsu_pkg::*;

   localparam int SZ_W  = $clog2(MAX_PEOPLE + 1);
   localparam int CNT_W = $clog2(MAX_PEOPLE + 1);
   localparam int EXT_W = (SZ_W > SIZE_OUT_W) ? SZ_W : SIZE_OUT_W;

   logic [IDX_W-1:0] id_mem   [MAX_PEOPLE];
   logic [SZ_W-1:0]  size_mem [MAX_PEOPLE];
   logic [IDX_W-1:0] next_mem [MAX_PEOPLE];

   logic             id_we, id_re_a, id_re_b;
   logic [IDX_W-1:0] id_waddr, id_wdata, id_raddr_a, id_raddr_b;
   logic [IDX_W-1:0] id_rd_a_ff, id_rd_b_ff;

   logic             size_we, size_re_a, size_re_b;
   logic [IDX_W-1:0] size_waddr, size_raddr_a, size_raddr_b;
   logic [SZ_W-1:0]  size_wdata, size_rd_a_ff, size_rd_b_ff;

   logic             next_we, next_re_a, next_re_b;
   logic [IDX_W-1:0] next_waddr, next_wdata, next_raddr_a, next_raddr_b;
   logic [IDX_W-1:0] next_rd_a_ff, next_rd_b_ff;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   op_type           op_ff, op_in;
   logic [IDX_W-1:0] elem_a_ff, elem_a_in, elem_b_ff, elem_b_in;
   logic [IDX_W-1:0] keep_rep_ff, keep_rep_in;
   logic [IDX_W-1:0] keep_elem_ff, keep_elem_in;
   logic [IDX_W-1:0] lose_elem_ff, lose_elem_in;
   logic [CNT_W-1:0] walk_cnt_ff, walk_cnt_in;

   op_type           cmd_op;
   logic [IDX_W-1:0] cmd_a, cmd_b;
   logic             b_wins;
   logic [EXT_W-1:0] size_ext;

   assign cmd_op   = op_type'(cmd_data[2*IDX_W]);
   assign cmd_a    = cmd_data[2*IDX_W-1:IDX_W];
   assign cmd_b    = cmd_data[IDX_W-1:0];
   assign b_wins   = size_rd_b_ff > size_rd_a_ff;
   assign size_ext = EXT_W'(size_rd_a_ff);
   assign rsp_data = size_ext[SIZE_OUT_W-1:0];
   assign clearing = (state_ff == ST_CLEAR);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      op_in        = op_ff;
      elem_a_in    = elem_a_ff;
      elem_b_in    = elem_b_ff;
      keep_rep_in  = keep_rep_ff;
      keep_elem_in = keep_elem_ff;
      lose_elem_in = lose_elem_ff;
      walk_cnt_in  = walk_cnt_ff;

      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      id_we        = 1'b0;
      id_waddr     = keep_rep_ff;
      id_wdata     = keep_rep_ff;
      id_re_a      = 1'b0;
      id_re_b      = 1'b0;
      id_raddr_a   = cmd_a;
      id_raddr_b   = cmd_b;
      size_we      = 1'b0;
      size_waddr   = keep_rep_ff;
      size_wdata   = size_rd_a_ff;
      size_re_a    = 1'b0;
      size_re_b    = 1'b0;
      size_raddr_a = id_rd_a_ff;
      size_raddr_b = id_rd_b_ff;
      next_we      = 1'b0;
      next_waddr   = keep_elem_ff;
      next_wdata   = next_rd_b_ff;
      next_re_a    = 1'b0;
      next_re_b    = 1'b0;
      next_raddr_a = next_rd_a_ff;
      next_raddr_b = lose_elem_ff;

      case (state_ff)
         ST_CLEAR: begin
            id_we      = 1'b1;
            id_waddr   = clr_cnt_ff;
            id_wdata   = clr_cnt_ff;
            size_we    = 1'b1;
            size_waddr = clr_cnt_ff;
            size_wdata = SZ_W'(1);
            next_we    = 1'b1;
            next_waddr = clr_cnt_ff;
            next_wdata = clr_cnt_ff;
            if (clr_cnt_ff == IDX_W'(MAX_PEOPLE - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               id_re_a   = 1'b1;
               id_re_b   = 1'b1;
               op_in     = cmd_op;
               elem_a_in = cmd_a;
               elem_b_in = cmd_b;
               state_in  = ST_ID;
            end
         end
         ST_ID: begin
            if (op_ff == OP_QUERY) begin
               size_re_a = 1'b1;
               state_in  = ST_QSIZE;
            end else if (id_rd_a_ff == id_rd_b_ff) begin
               state_in = ST_IDLE;
            end else begin
               size_re_a = 1'b1;
               size_re_b = 1'b1;
               state_in  = ST_SIZE;
            end
         end
         ST_QSIZE: begin
            // hold the result until the result queue has room
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SIZE: begin
            // on a tie the first element's set survives
            keep_rep_in  = b_wins ? id_rd_b_ff : id_rd_a_ff;
            keep_elem_in = b_wins ? elem_b_ff : elem_a_ff;
            lose_elem_in = b_wins ? elem_a_ff : elem_b_ff;
            size_we      = 1'b1;
            size_waddr   = keep_rep_in;
            size_wdata   = size_rd_a_ff + size_rd_b_ff;
            id_we        = 1'b1;
            id_waddr     = lose_elem_in;
            id_wdata     = keep_rep_in;
            next_re_a    = 1'b1;
            next_raddr_a = lose_elem_in;
            walk_cnt_in  = CNT_W'(1);
            state_in     = ST_WALK;
         end
         ST_WALK: begin
            if ((next_rd_a_ff == lose_elem_ff) || (walk_cnt_ff == CNT_W'(MAX_PEOPLE))) begin
               // walk done: fetch both links for the splice
               next_re_a    = 1'b1;
               next_raddr_a = keep_elem_ff;
               next_re_b    = 1'b1;
               next_raddr_b = lose_elem_ff;
               state_in     = ST_SPLICE1;
            end else begin
               id_we        = 1'b1;
               id_waddr     = next_rd_a_ff;
               id_wdata     = keep_rep_ff;
               next_re_a    = 1'b1;
               next_raddr_a = next_rd_a_ff;
               walk_cnt_in  = walk_cnt_ff + 1'b1;
            end
         end
         ST_SPLICE1: begin
            // keep's link takes lose's old link; lose's link is written next
            next_we    = 1'b1;
            next_waddr = keep_elem_ff;
            next_wdata = next_rd_b_ff;
            elem_a_in  = next_rd_a_ff;
            state_in   = ST_IDLE;
            op_in      = OP_MERGE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Second splice write happens on the cycle after ST_SPLICE1, out of idle
   logic splice2_ff, splice2_in;
   assign splice2_in = (state_ff == ST_SPLICE1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         splice2_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         splice2_ff <= splice2_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      elem_a_ff    <= elem_a_in;
      elem_b_ff    <= elem_b_in;
      keep_rep_ff  <= keep_rep_in;
      keep_elem_ff <= keep_elem_in;
      lose_elem_ff <= lose_elem_in;
      walk_cnt_ff  <= walk_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_waddr] <= id_wdata;
      end
      if (id_re_a) begin
         id_rd_a_ff <= id_mem[id_raddr_a];
      end
      if (id_re_b) begin
         id_rd_b_ff <= id_mem[id_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_waddr] <= size_wdata;
      end
      if (size_re_a) begin
         size_rd_a_ff <= size_mem[size_raddr_a];
      end
      if (size_re_b) begin
         size_rd_b_ff <= size_mem[size_raddr_b];
      end
   end

   // The member-list memory takes the second splice write from splice2_ff;
   // the sequencer never writes it in ST_IDLE, so the port is free then.
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end else if (splice2_ff) begin
         next_mem[lose_elem_ff] <= elem_a_ff;
      end
      if (next_re_a) begin
         next_rd_a_ff <= next_mem[next_raddr_a];
      end
      if (next_re_b) begin
         next_rd_b_ff <= next_mem[next_raddr_b];
      end
   end

endmodule

// ===== design/disjoint_set_union_by_size.sv =====
`timescale 1ns / 1ps
// Disjoint-set union by size: a front end that folds indices into range, a
// command queue, and a back end that owns the set memories. After reset the
// block initializes every entry of its memories, with full held high; then
// a query goes through the back-end steps set-id read, size read and result
// push, and a merge of two distinct sets reads both set ids and sizes, then
// relabels each member of the smaller set and splices the member lists; the
// relabel walk follows the member list one read of that memory per cycle.
// A merge within one set ends after the set-id read. The front end registers
// requests in s1 and s2; results wait in a two-entry queue until popped.
// Depends on dsu_pkg, dsu_front, dsu_fifo and dsu_back.
module disjoint_set_union_by_size #(
   parameter int MAX_PEOPLE = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  dsu_pkg::op_type                req_type,
   input  logic [dsu_pkg::IDX_IN_W-1:0]   req_first_index,
   input  logic [dsu_pkg::IDX_IN_W-1:0]   req_second_index,
   output logic                           empty,
   input  logic                           pop,
   output logic [dsu_pkg::SIZE_OUT_W-1:0] rsp_set_size
);
   import dsu_pkg::*;

   localparam int IDX_W = $clog2(MAX_PEOPLE);
   localparam int CMD_W = 2 * IDX_W + 1;

   logic                  cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0]      cmd_in_data, cmd_out_data;
   logic                  rsp_push, rsp_full;
   logic [SIZE_OUT_W-1:0] rsp_data;
   logic                  clearing;

   dsu_front #(
      .MAX_PEOPLE (MAX_PEOPLE),
      .IDX_W      (IDX_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_type),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .hold             (clearing),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_in_data),
      .cmd_full         (cmd_full)
   );

   dsu_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (4)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   dsu_back #(
      .MAX_PEOPLE (MAX_PEOPLE),
      .IDX_W      (IDX_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .rsp_full  (rsp_full),
      .clearing  (clearing)
   );

   dsu_fifo #(
      .WIDTH (SIZE_OUT_W),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_set_size),
      .empty     (empty)
   );

endmodule
